// ===== rtl/rldr_pkg.sv =====
// shared types, constants and helpers for the radial lens distortion remap
package rldr_pkg;

    localparam int MAX_DIM    = 16384;
    localparam int DIV_STEPS  = 29;
    localparam int SQRT_STEPS = 31;
    localparam int SQRT_TOP   = 60;
    // div entry, div steps, uv/au/sq/sum, sqrt steps, nine arithmetic stages
    localparam int PIPE_DEPTH = 1 + DIV_STEPS + 4 + SQRT_STEPS + 9;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = 2;

    localparam logic [2:0] REG_QUAD   = 3'd0;
    localparam logic [2:0] REG_CUBIC  = 3'd1;
    localparam logic [2:0] REG_ASPECT = 3'd2;
    localparam logic [2:0] REG_FW     = 3'd3;
    localparam logic [2:0] REG_FH     = 3'd4;
    localparam logic [2:0] REG_PW     = 3'd5;
    localparam logic [2:0] REG_PH     = 3'd6;

    typedef struct packed {
        logic [31:0] quad;
        logic [31:0] cubic;
        logic [18:0] aspect;
        logic [14:0] fw;
        logic [14:0] fh;
        logic [13:0] pw;
        logic [13:0] ph;
    } cfg_t;

    typedef struct packed {
        logic [13:0] px;
        logic [13:0] py;
        logic        ovx;
        logic        ovy;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [14:0] dim_clamp(input logic [14:0] d);
        logic [14:0] r;
        r = d;
        if (d == 15'd0) begin
            r = 15'd1;
        end else if (d > 15'(MAX_DIM)) begin
            r = 15'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

// ===== rtl/rldr_front.sv =====
// input stage: takes pixel items and flags coordinates far outside the frame
module rldr_front import rldr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // pixel_x [13:0], pixel_y [27:14]
    input  cfg_t        cfg,
    input  q_stat_t     q_stat,
    output logic        push,
    output item_t       push_item
);

    logic        hold_vld_reg, hold_vld_next;
    item_t       hold_item_reg, hold_item_next;
    logic [14:0] w, h;
    logic        take;

    assign w = dim_clamp(cfg.fw);
    assign h = dim_clamp(cfg.fh);

    assign push     = hold_vld_reg && !q_stat.full;
    assign s_tready = !hold_vld_reg || !q_stat.full;
    assign take     = s_tvalid && s_tready;
    assign push_item = hold_item_reg;

    always_comb begin
        hold_vld_next  = hold_vld_reg;
        hold_item_next = hold_item_reg;
        if (push) begin
            hold_vld_next = 1'b0;
        end
        if (take) begin
            hold_vld_next      = 1'b1;
            hold_item_next.px  = s_tdata[13:0];
            hold_item_next.py  = s_tdata[27:14];
            // quotient would reach 2^29: centred value saturates anyway
            hold_item_next.ovx = {5'b0, s_tdata[13:4]} >= w;
            hold_item_next.ovy = {5'b0, s_tdata[27:18]} >= h;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_vld_reg <= 1'b0;
        end else begin
            hold_vld_reg <= hold_vld_next;
        end
        hold_item_reg <= hold_item_next;
    end

endmodule

// ===== rtl/rldr_queue.sv =====
// short queue between the front stage and the arithmetic pipeline
module rldr_queue import rldr_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  item_t   push_item,
    input  logic    pop,
    output item_t   pop_item,
    output q_stat_t q_stat
);

    item_t           mem [0:Q_DEPTH-1];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   cnt_reg, cnt_next;

    assign q_stat.full  = cnt_reg == (Q_AW+1)'(Q_DEPTH);
    assign q_stat.empty = cnt_reg == '0;
    assign pop_item     = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/rldr_back.sv =====
// arithmetic pipeline: divide, radius, square root, distortion factor, rescale
module rldr_back import rldr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  q_stat_t     q_stat,
    input  item_t       pop_item,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata   // source_x [31:0], source_y [63:32]
);

    logic [14:0] w, h;
    logic        adv;
    logic [PIPE_DEPTH-1:0] vld_reg, vld_next;

    assign w = dim_clamp(cfg.fw);
    assign h = dim_clamp(cfg.fh);
    assign adv = !vld_reg[PIPE_DEPTH-1] || m_tready;
    assign pop = adv && !q_stat.empty;
    assign vld_next = {vld_reg[PIPE_DEPTH-2:0], pop};

    // restoring dividers, one quotient bit per stage
    logic [14:0] dv_rx_reg [0:DIV_STEPS];
    logic [14:0] dv_ry_reg [0:DIV_STEPS];
    logic [28:0] dv_qx_reg [0:DIV_STEPS];
    logic [28:0] dv_qy_reg [0:DIV_STEPS];
    logic [3:0]  dv_xl_reg [0:DIV_STEPS];
    logic [3:0]  dv_yl_reg [0:DIV_STEPS];
    logic        dv_ox_reg [0:DIV_STEPS];
    logic        dv_oy_reg [0:DIV_STEPS];
    logic [14:0] dv_rx_next [0:DIV_STEPS];
    logic [14:0] dv_ry_next [0:DIV_STEPS];
    logic [28:0] dv_qx_next [0:DIV_STEPS];
    logic [28:0] dv_qy_next [0:DIV_STEPS];
    logic [3:0]  dv_xl_next [0:DIV_STEPS];
    logic [3:0]  dv_yl_next [0:DIV_STEPS];
    logic        dv_ox_next [0:DIV_STEPS];
    logic        dv_oy_next [0:DIV_STEPS];

    always_comb begin
        logic [15:0] tx;
        logic [15:0] ty;
        logic        gx;
        logic        gy;
        dv_rx_next[0] = {5'b0, pop_item.px[13:4]};
        dv_ry_next[0] = {5'b0, pop_item.py[13:4]};
        dv_qx_next[0] = '0;
        dv_qy_next[0] = '0;
        dv_xl_next[0] = pop_item.px[3:0];
        dv_yl_next[0] = pop_item.py[3:0];
        dv_ox_next[0] = pop_item.ovx;
        dv_oy_next[0] = pop_item.ovy;
        for (int j = 0; j < DIV_STEPS; j++) begin
            tx = {dv_rx_reg[j], dv_xl_reg[j][3]};
            ty = {dv_ry_reg[j], dv_yl_reg[j][3]};
            gx = tx >= {1'b0, w};
            gy = ty >= {1'b0, h};
            dv_rx_next[j+1] = gx ? 15'(tx - {1'b0, w}) : tx[14:0];
            dv_ry_next[j+1] = gy ? 15'(ty - {1'b0, h}) : ty[14:0];
            dv_qx_next[j+1] = {dv_qx_reg[j][27:0], gx};
            dv_qy_next[j+1] = {dv_qy_reg[j][27:0], gy};
            dv_xl_next[j+1] = {dv_xl_reg[j][2:0], 1'b0};
            dv_yl_next[j+1] = {dv_yl_reg[j][2:0], 1'b0};
            dv_ox_next[j+1] = dv_ox_reg[j];
            dv_oy_next[j+1] = dv_oy_reg[j];
        end
    end

    // centred coordinates and magnitudes
    logic signed [27:0] uv_u_reg, uv_v_reg, uv_u_next, uv_v_next;
    logic [26:0]        uv_ua_reg, uv_va_reg, uv_ua_next, uv_va_next;

    always_comb begin
        logic signed [29:0] cx;
        logic signed [29:0] cy;
        logic [27:0]        nx;
        logic [27:0]        ny;
        cx = $signed({1'b0, dv_qx_reg[DIV_STEPS]}) - 30'sd16777216;
        cy = $signed({1'b0, dv_qy_reg[DIV_STEPS]}) - 30'sd16777216;
        uv_u_next = (dv_ox_reg[DIV_STEPS] || cx > 30'sd134217727) ?
                    28'sd134217727 : cx[27:0];
        uv_v_next = (dv_oy_reg[DIV_STEPS] || cy > 30'sd134217727) ?
                    28'sd134217727 : cy[27:0];
        nx = 28'(-uv_u_next);
        ny = 28'(-uv_v_next);
        uv_ua_next = uv_u_next[27] ? nx[26:0] : uv_u_next[26:0];
        uv_va_next = uv_v_next[27] ? ny[26:0] : uv_v_next[26:0];
    end

    // aspect scaling, squares, radius sum
    logic [29:0]        au_reg;
    logic [26:0]        au_va_reg;
    logic signed [27:0] au_u_reg, au_v_reg;
    logic [45:0]        au_prod;
    logic [59:0]        sq_au2_reg;
    logic [53:0]        sq_v2_reg;
    logic signed [27:0] sq_u_reg, sq_v_reg;
    logic [60:0]        sum_s;

    assign au_prod = cfg.aspect * uv_ua_reg;
    assign sum_s   = {1'b0, sq_au2_reg} + 61'(sq_v2_reg);

    // square root, one result bit per stage
    logic [61:0]        sq_n_reg [0:SQRT_STEPS];
    logic [61:0]        sq_r_reg [0:SQRT_STEPS];
    logic signed [27:0] sq_pu_reg [0:SQRT_STEPS];
    logic signed [27:0] sq_pv_reg [0:SQRT_STEPS];
    logic [40:0]        sq_r2_reg [0:SQRT_STEPS];
    logic [61:0]        sq_n_next [0:SQRT_STEPS];
    logic [61:0]        sq_r_next [0:SQRT_STEPS];

    always_comb begin
        logic [61:0] bt;
        logic [61:0] tr;
        sq_n_next[0] = 62'(sum_s);
        sq_r_next[0] = '0;
        for (int j = 0; j < SQRT_STEPS; j++) begin
            bt = 62'd1 << (SQRT_TOP - 2*j);
            tr = sq_r_reg[j] + bt;
            if (sq_n_reg[j] >= tr) begin
                sq_n_next[j+1] = sq_n_reg[j] - tr;
                sq_r_next[j+1] = (sq_r_reg[j] >> 1) + bt;
            end else begin
                sq_n_next[j+1] = sq_n_reg[j];
                sq_r_next[j+1] = sq_r_reg[j] >> 1;
            end
        end
    end

    // cubic term and combined coefficient
    logic signed [31:0] kq, kc;
    logic               cub_en;
    logic [31:0]        km;
    logic [62:0]        cm_prod;
    logic [38:0]        cm_c_reg;
    logic signed [27:0] cm_u_reg, cm_v_reg, t_u_reg, t_v_reg;
    logic [40:0]        cm_r2_reg, t_r2_reg;
    logic signed [40:0] t_val;
    logic signed [40:0] c_term;
    logic [40:0]        t_neg_val;
    logic               t_neg_reg;
    logic [39:0]        t_mag_reg;

    assign kq      = $signed(cfg.quad);
    assign kc      = $signed(cfg.cubic);
    assign cub_en  = kc > 32'sd2684 || kc < -32'sd2684;
    assign km      = kc[31] ? 32'(-kc) : cfg.cubic;
    assign cm_prod = km * sq_r_reg[SQRT_STEPS][30:0];
    assign c_term  = !cub_en ? 41'sd0 :
                     (kc[31] ? -$signed({2'b0, cm_c_reg}) : $signed({2'b0, cm_c_reg}));
    assign t_val     = 41'(kq) + c_term;
    assign t_neg_val = 41'(-t_val);

    // r2 times |t| in four partial products
    logic [40:0]        pp_ll_reg, pp_lh_reg;
    logic [39:0]        pp_hl_reg, pp_hh_reg;
    logic               pp_neg_reg, pr_neg_reg;
    logic signed [27:0] pp_u_reg, pp_v_reg, pr_u_reg, pr_v_reg;
    logic [80:0]        pr_sum;
    logic               pr_big_reg;
    logic [34:0]        pr_p_reg;

    assign pr_sum = 81'(pp_ll_reg) + (81'(pp_lh_reg) << 20) + (81'(pp_hl_reg) << 21)
                  + (81'(pp_hh_reg) << 41);

    // factor and rescale
    logic signed [36:0] f_val, f_reg;
    logic signed [36:0] p_ext;
    logic signed [27:0] f_u_reg, f_v_reg;
    logic signed [46:0] uf_lx_reg, uf_hx_reg, uf_ly_reg, uf_hy_reg;
    logic signed [65:0] cs_sx, cs_sy;
    logic signed [37:0] cs_x_reg, cs_y_reg;
    logic signed [38:0] wm_bx, wm_by;
    logic signed [54:0] wm_x_reg, wm_y_reg;
    logic signed [39:0] o_x, o_y;
    logic [31:0]        sx_reg, sy_reg, sx_next, sy_next;

    assign p_ext = $signed({2'b0, pr_p_reg});
    assign f_val = pr_big_reg ? (pr_neg_reg ? -37'sd34359738367 : 37'sd34359738367) :
                   (pr_neg_reg ? 37'sd268435456 - p_ext : 37'sd268435456 + p_ext);
    assign cs_sx = (66'(uf_hx_reg) <<< 18) + 66'(uf_lx_reg);
    assign cs_sy = (66'(uf_hy_reg) <<< 18) + 66'(uf_ly_reg);
    assign wm_bx = 39'(cs_x_reg) + 39'sd16777216;
    assign wm_by = 39'(cs_y_reg) + 39'sd16777216;
    assign o_x = 40'(wm_x_reg >>> 17) + $signed({18'b0, cfg.pw, 8'h80});
    assign o_y = 40'(wm_y_reg >>> 17) + $signed({18'b0, cfg.ph, 8'h80});

    always_comb begin
        sx_next = o_x[31:0];
        sy_next = o_y[31:0];
        if (o_x > 40'sd2147483647) begin
            sx_next = 32'h7FFF_FFFF;
        end else if (o_x < -40'sd2147483648) begin
            sx_next = 32'h8000_0000;
        end
        if (o_y > 40'sd2147483647) begin
            sy_next = 32'h7FFF_FFFF;
        end else if (o_y < -40'sd2147483648) begin
            sy_next = 32'h8000_0000;
        end
    end

    assign m_tvalid = vld_reg[PIPE_DEPTH-1];
    assign m_tdata  = {sy_reg, sx_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j <= DIV_STEPS; j++) begin
                dv_rx_reg[j] <= dv_rx_next[j];
                dv_ry_reg[j] <= dv_ry_next[j];
                dv_qx_reg[j] <= dv_qx_next[j];
                dv_qy_reg[j] <= dv_qy_next[j];
                dv_xl_reg[j] <= dv_xl_next[j];
                dv_yl_reg[j] <= dv_yl_next[j];
                dv_ox_reg[j] <= dv_ox_next[j];
                dv_oy_reg[j] <= dv_oy_next[j];
            end
            uv_u_reg  <= uv_u_next;
            uv_v_reg  <= uv_v_next;
            uv_ua_reg <= uv_ua_next;
            uv_va_reg <= uv_va_next;
            au_reg    <= au_prod[45:16];
            au_va_reg <= uv_va_reg;
            au_u_reg  <= uv_u_reg;
            au_v_reg  <= uv_v_reg;
            sq_au2_reg <= au_reg * au_reg;
            sq_v2_reg  <= au_va_reg * au_va_reg;
            sq_u_reg   <= au_u_reg;
            sq_v_reg   <= au_v_reg;
            sq_pu_reg[0] <= sq_u_reg;
            sq_pv_reg[0] <= sq_v_reg;
            sq_r2_reg[0] <= sum_s[60:20];
            for (int j = 0; j <= SQRT_STEPS; j++) begin
                sq_n_reg[j] <= sq_n_next[j];
                sq_r_reg[j] <= sq_r_next[j];
            end
            for (int j = 0; j < SQRT_STEPS; j++) begin
                sq_pu_reg[j+1] <= sq_pu_reg[j];
                sq_pv_reg[j+1] <= sq_pv_reg[j];
                sq_r2_reg[j+1] <= sq_r2_reg[j];
            end
            cm_c_reg  <= cm_prod[62:24];
            cm_u_reg  <= sq_pu_reg[SQRT_STEPS];
            cm_v_reg  <= sq_pv_reg[SQRT_STEPS];
            cm_r2_reg <= sq_r2_reg[SQRT_STEPS];
            t_neg_reg <= t_val[40];
            t_mag_reg <= t_val[40] ? t_neg_val[39:0] : t_val[39:0];
            t_u_reg   <= cm_u_reg;
            t_v_reg   <= cm_v_reg;
            t_r2_reg  <= cm_r2_reg;
            pp_ll_reg  <= t_r2_reg[20:0] * t_mag_reg[19:0];
            pp_lh_reg  <= t_r2_reg[20:0] * t_mag_reg[39:20];
            pp_hl_reg  <= t_r2_reg[40:21] * t_mag_reg[19:0];
            pp_hh_reg  <= t_r2_reg[40:21] * t_mag_reg[39:20];
            pp_neg_reg <= t_neg_reg;
            pp_u_reg   <= t_u_reg;
            pp_v_reg   <= t_v_reg;
            pr_big_reg <= pr_sum > (81'd1 << 62);
            pr_p_reg   <= pr_sum[62:28];
            pr_neg_reg <= pp_neg_reg;
            pr_u_reg   <= pp_u_reg;
            pr_v_reg   <= pp_v_reg;
            f_reg   <= f_val;
            f_u_reg <= pr_u_reg;
            f_v_reg <= pr_v_reg;
            uf_lx_reg <= f_u_reg * $signed({1'b0, f_reg[17:0]});
            uf_hx_reg <= f_u_reg * $signed(f_reg[36:18]);
            uf_ly_reg <= f_v_reg * $signed({1'b0, f_reg[17:0]});
            uf_hy_reg <= f_v_reg * $signed(f_reg[36:18]);
            cs_x_reg <= cs_sx[65:28];
            cs_y_reg <= cs_sy[65:28];
            wm_x_reg <= wm_bx * $signed({1'b0, w});
            wm_y_reg <= wm_by * $signed({1'b0, h});
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
    end

endmodule

// ===== rtl/radial_lens_distortion_remap_top.sv =====
// top level: register port, front stage, queue and arithmetic pipeline
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata: pixel_x, pixel_y
//  m_        out  m_tvalid/m_tready  m_tdata: source_x, source_y
//  apb       in   psel/penable       paddr, pwdata, prdata
//
// one item per cycle while the output is not stalled; each item passes the front
// register, the queue and then the back pipeline, whose depth is set mostly by
// the 29-step divider and the 31-step square root.
// reset clears all valid flags and loads the register defaults.
// a stalled output freezes the back pipeline; the queue and front register
// keep taking items until they fill.
module radial_lens_distortion_remap_top import rldr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // pixel_x [13:0], pixel_y [27:14]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // source_x [31:0], source_y [63:32]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t       cfg_reg, cfg_next;
    logic       cfg_wr;
    logic [2:0] ridx;
    q_stat_t    q_stat;
    logic       push, pop;
    item_t      push_item, pop_item;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign ridx   = paddr[4:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (ridx)
                REG_QUAD:   cfg_next.quad   = pwdata;
                REG_CUBIC:  cfg_next.cubic  = pwdata;
                REG_ASPECT: cfg_next.aspect = pwdata[18:0];
                REG_FW:     cfg_next.fw     = pwdata[14:0];
                REG_FH:     cfg_next.fh     = pwdata[14:0];
                REG_PW:     cfg_next.pw     = pwdata[13:0];
                REG_PH:     cfg_next.ph     = pwdata[13:0];
                default:    cfg_next        = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            REG_QUAD:   prdata = cfg_reg.quad;
            REG_CUBIC:  prdata = cfg_reg.cubic;
            REG_ASPECT: prdata = {13'b0, cfg_reg.aspect};
            REG_FW:     prdata = {17'b0, cfg_reg.fw};
            REG_FH:     prdata = {17'b0, cfg_reg.fh};
            REG_PW:     prdata = {18'b0, cfg_reg.pw};
            REG_PH:     prdata = {18'b0, cfg_reg.ph};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.quad   <= 32'hFFB5_3501;
            cfg_reg.cubic  <= 32'd0;
            cfg_reg.aspect <= 19'd87163;
            cfg_reg.fw     <= 15'd1024;
            cfg_reg.fh     <= 15'd1024;
            cfg_reg.pw     <= 14'd0;
            cfg_reg.ph     <= 14'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rldr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg       (cfg_reg),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    rldr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_stat    (q_stat)
    );

    rldr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_stat   (q_stat),
        .pop_item (pop_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_queue_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("item pushed into full queue");

    a_quad_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr && ridx == REG_QUAD) |=> cfg_reg.quad == $past(pwdata))
        else $error("quadratic coefficient write lost");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid straight after reset");

endmodule
